// ===== rtl/core/cnms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_pkg
// shared types and constants of the conditional neighbour mean smoother
// ----------------------------------------------------------------------------
package cnms_pkg;

  localparam int MAX_LINE   = 32;
  localparam int MAX_LINES  = 1024;
  localparam int VALUE_BITS = 32;
  localparam int COL_BITS   = $clog2(MAX_LINE);
  localparam int ROW_BITS   = $clog2(MAX_LINES);
  localparam int LEN_BITS   = 6;
  localparam int CNT_BITS   = 11;
  localparam int BANK_BITS  = 2;
  localparam int SUM_BITS   = VALUE_BITS + 4;
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int IDX_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD   = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_MODE        = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_LINE_LENGTH = 8'd2;
  localparam logic [IDX_BITS-1:0] REG_LINE_COUNT  = 8'd3;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_CROSS = 2'd1,
    MODE_INNER = 2'd2,
    MODE_OUTER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    F_IDLE, F_JA, F_JB, F_FL
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FETCH, B_WAIT, B_DPREP, B_DIV, B_SIGN, B_OUT
  } back_state_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] threshold;
    mode_t                        mode;
    logic [LEN_BITS-1:0]          len;
    logic [CNT_BITS-1:0]          rows;
  } cfg_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] bank_up;
    logic [BANK_BITS-1:0] bank_mid;
    logic [BANK_BITS-1:0] bank_down;
    logic                 has_up;
    logic                 has_down;
    logic [COL_BITS-1:0]  col;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [BANK_BITS-1:0]  bank;
    logic [COL_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] data;
  } wr_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/conditional_neighbour_mean_smoother_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conditional_neighbour_mean_smoother_top
// conditional 3x3 / cross / axis-pair mean filter over a raster grid
// ----------------------------------------------------------------------------
// bins enter in raster order, one line of line_length bins after another,
// line_count lines per frame. a bin below threshold leaves as the mean
// (truncated toward zero) of itself and its in-range original neighbours,
// any other bin leaves unchanged. output lags by one line plus one bin;
// the last bin of a frame flushes its final line, and m_tlast marks the
// last bin of the frame. the block works one input beat at a time: a beat
// is taken only once every result job of the previous beat has finished.
// in the front a beat passes the take, first-job and second-job steps in
// turn, waiting in a job step while the job queue is full.
// in the back each result is popped from the queue and reads its neighbours
// one by one from the line bank memory (up to 9 reads), skipping slots that
// are out of range or outside the mode, then runs a bit-serial divide when
// smoothing applies and ends with the output hand-off; a bin kept unchanged
// goes to the output hand-off straight after its own read. a line-end beat
// produces up to two results, and the frame's last beat up to
// line_length + 2.
// writing line_length or line_count restarts the frame.
// ----------------------------------------------------------------------------
module conditional_neighbour_mean_smoother_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream: [31:0] bin_value
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // output stream: [31:0] smoothed_value; frame_end travels as m_tlast
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic             m_tlast,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import cnms_pkg::*;

  logic signed [VALUE_BITS-1:0] threshold;
  mode_t                        mode;
  logic [LEN_BITS-1:0]          line_length;
  logic [CNT_BITS-1:0]          line_count;
  cfg_t                         cfg;
  logic                         cfg_we;
  logic                         restart;

  back_status_t back_status;
  job_t         push_job, pop_job;
  logic         q_push, q_pop, q_full, q_empty;
  wr_t          wr;

  // registers take writes at any time; host keeps to idle periods
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == REG_LINE_LENGTH || cfg_index == REG_LINE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= 32'sd65536;
      mode        <= MODE_FULL;
      line_length <= LEN_BITS'(6);
      line_count  <= CNT_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold   <= signed'(cfg_data);
        REG_MODE:        mode        <= mode_t'(cfg_data[1:0]);
        REG_LINE_LENGTH: line_length <= cfg_data[LEN_BITS-1:0];
        REG_LINE_COUNT:  line_count  <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // geometry clamped to what the line banks and row counter hold
  always_comb begin
    cfg.threshold = threshold;
    cfg.mode      = mode;
    if (line_length == '0) begin
      cfg.len = LEN_BITS'(1);
    end else if (line_length > LEN_BITS'(MAX_LINE)) begin
      cfg.len = LEN_BITS'(MAX_LINE);
    end else begin
      cfg.len = line_length;
    end
    if (line_count == '0) begin
      cfg.rows = CNT_BITS'(1);
    end else if (line_count > CNT_BITS'(MAX_LINES)) begin
      cfg.rows = CNT_BITS'(MAX_LINES);
    end else begin
      cfg.rows = line_count;
    end
  end

  // front: raster position, bank rotation, job issue
  cnms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .back_status (back_status),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .q_push      (q_push),
    .q_job       (push_job),
    .wr          (wr)
  );

  // one job per result
  cnms_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // back: neighbour reads, mean, output register
  cnms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .wr       (wr),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .status   (back_status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/core/cnms_job_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_job_queue
// short fifo of per-result jobs between front and back
// ----------------------------------------------------------------------------
module cnms_job_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cnms_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output cnms_pkg::job_t     pop_job,
  output logic               empty
);
  import cnms_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  job_t                slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wp;
  logic [PTR_BITS-1:0] rp;
  logic [PTR_BITS:0]   count;

  assign full    = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= rp + 1'b1;
      end
      count <= count + (PTR_BITS+1)'(push && !full) - (PTR_BITS+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cnms_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_front
// takes bins, tracks raster position and line banks, issues result jobs
// ----------------------------------------------------------------------------
module cnms_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cnms_pkg::cfg_t                 cfg,
  input  wire logic                           restart,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [cnms_pkg::VALUE_BITS-1:0] s_tdata,
  input  wire cnms_pkg::back_status_t         back_status,
  input  wire logic                           q_full,
  input  wire logic                           q_empty,
  output logic                                q_push,
  output cnms_pkg::job_t                      q_job,
  output cnms_pkg::wr_t                       wr
);
  import cnms_pkg::*;

  front_state_t         state, state_next;
  logic [ROW_BITS-1:0]  r;
  logic [COL_BITS-1:0]  c;
  logic [ROW_BITS-1:0]  jr;
  logic [COL_BITS-1:0]  jc;
  logic                 jlast_bin, jlast_line;
  logic [COL_BITS-1:0]  fi;
  logic [BANK_BITS-1:0] prev_b, cur_b, inc_b;
  logic                 accept, last_bin, last_line, rotate;
  logic [COL_BITS-1:0]  len_m1;

  assign len_m1    = COL_BITS'(cfg.len - 1'b1);
  assign last_bin  = (c == len_m1);
  assign last_line = ({1'b0, r} + 1'b1 == cfg.rows);
  assign s_tready  = (state == F_IDLE) && q_empty && back_status.idle;
  assign accept    = s_tvalid && s_tready;

  assign wr.en   = accept;
  assign wr.bank = inc_b;
  assign wr.col  = c;
  assign wr.data = s_tdata;

  always_comb begin
    state_next     = state;
    q_push         = 1'b0;
    rotate         = 1'b0;
    q_job.bank_up   = prev_b;
    q_job.bank_mid  = cur_b;
    q_job.bank_down = inc_b;
    q_job.has_up    = (jr >= ROW_BITS'(2));
    q_job.has_down  = 1'b1;
    q_job.col       = jc - 1'b1;
    q_job.last      = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = F_JA;
        end
      end
      F_JA: begin
        if (jr != '0 && jc != '0) begin
          q_push = !q_full;
          if (!q_full) begin
            state_next = F_JB;
          end
        end else begin
          state_next = F_JB;
        end
      end
      F_JB: begin
        q_job.col = jc;
        if (jr != '0 && jlast_bin) begin
          q_push = !q_full;
        end
        if (!(jr != '0 && jlast_bin) || !q_full) begin
          if (jlast_bin && jlast_line) begin
            state_next = F_FL;
          end else begin
            rotate     = jlast_bin;
            state_next = F_IDLE;
          end
        end
      end
      F_FL: begin
        q_job.bank_up   = cur_b;
        q_job.bank_mid  = inc_b;
        q_job.has_up    = (jr != '0);
        q_job.has_down  = 1'b0;
        q_job.col       = fi;
        q_job.last      = (fi == len_m1);
        q_push          = !q_full;
        if (!q_full && fi == len_m1) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      r      <= '0;
      c      <= '0;
      fi     <= '0;
      prev_b <= BANK_BITS'(0);
      cur_b  <= BANK_BITS'(1);
      inc_b  <= BANK_BITS'(2);
    end else begin
      state <= state_next;
      if (restart) begin
        r <= '0;
        c <= '0;
      end else if (accept) begin
        c <= last_bin ? '0 : c + 1'b1;
        if (last_bin) begin
          r <= last_line ? '0 : r + 1'b1;
        end
      end
      if (accept) begin
        fi <= '0;
      end else if (state == F_FL && !q_full) begin
        fi <= fi + 1'b1;
      end
      if (rotate) begin
        prev_b <= cur_b;
        cur_b  <= inc_b;
        inc_b  <= prev_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      jr         <= r;
      jc         <= c;
      jlast_bin  <= last_bin;
      jlast_line <= last_line;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cnms_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_back
// line bank memory, neighbour accumulation, serial divide, output register
// ----------------------------------------------------------------------------
module cnms_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cnms_pkg::cfg_t                  cfg,
  input  wire cnms_pkg::wr_t                   wr,
  input  wire logic                            q_empty,
  input  wire cnms_pkg::job_t                  q_job,
  output logic                                 q_pop,
  output cnms_pkg::back_status_t               status,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [cnms_pkg::VALUE_BITS-1:0]      m_tdata,
  output logic                                 m_tlast
);
  import cnms_pkg::*;

  localparam int ADDR_BITS = BANK_BITS + COL_BITS;

  logic [VALUE_BITS-1:0] mem [2**ADDR_BITS];
  logic [VALUE_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0]  rd_addr;

  back_state_t            state, state_next;
  job_t                   job;
  logic [3:0]             k;
  logic signed [SUM_BITS-1:0] sum;
  logic [3:0]             n;
  logic [MAG_BITS-1:0]    dvd;
  logic [3:0]             rem;
  logic [5:0]             cnt;
  logic                   neg;
  logic [VALUE_BITS-1:0]  res;
  logic                   step_en, left, right, full_m;
  logic [BANK_BITS-1:0]   sel_bank;
  logic [COL_BITS-1:0]    sel_col;
  logic [4:0]             trial;
  logic signed [SUM_BITS-1:0] rd_ext;
  logic                   out_free;

  assign left     = (job.col != '0);
  assign right    = ({1'b0, job.col} + 1'b1 < cfg.len);
  assign full_m   = (cfg.mode == MODE_FULL);
  assign rd_ext   = SUM_BITS'(signed'(rd_data));
  assign trial    = {rem, dvd[MAG_BITS-1]};
  assign out_free = !m_tvalid || m_tready;
  assign status.idle = (state == B_IDLE);
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // neighbour order: self, left, right, up, down, then the four corners
  always_comb begin
    step_en  = 1'b0;
    sel_bank = job.bank_mid;
    sel_col  = job.col;
    case (k)
      4'd0: step_en = 1'b1;
      4'd1: begin
        step_en = (cfg.mode != MODE_OUTER) && left;
        sel_col = job.col - 1'b1;
      end
      4'd2: begin
        step_en = (cfg.mode != MODE_OUTER) && right;
        sel_col = job.col + 1'b1;
      end
      4'd3: begin
        step_en  = (cfg.mode != MODE_INNER) && job.has_up;
        sel_bank = job.bank_up;
      end
      4'd4: begin
        step_en  = (cfg.mode != MODE_INNER) && job.has_down;
        sel_bank = job.bank_down;
      end
      4'd5: begin
        step_en  = full_m && job.has_up && left;
        sel_bank = job.bank_up;
        sel_col  = job.col - 1'b1;
      end
      4'd6: begin
        step_en  = full_m && job.has_up && right;
        sel_bank = job.bank_up;
        sel_col  = job.col + 1'b1;
      end
      4'd7: begin
        step_en  = full_m && job.has_down && left;
        sel_bank = job.bank_down;
        sel_col  = job.col - 1'b1;
      end
      4'd8: begin
        step_en  = full_m && job.has_down && right;
        sel_bank = job.bank_down;
        sel_col  = job.col + 1'b1;
      end
      default: step_en = 1'b0;
    endcase
  end

  assign rd_addr = {sel_bank, sel_col};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.col}] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_FETCH;
      B_FETCH: begin
        if (step_en) state_next = B_WAIT;
        else if (k == 4'd8) state_next = B_DPREP;
      end
      B_WAIT: begin
        if (k == 4'd0 && signed'(rd_data) >= signed'(cfg.threshold)) state_next = B_OUT;
        else if (k == 4'd8) state_next = B_DPREP;
        else state_next = B_FETCH;
      end
      B_DPREP: state_next = B_DIV;
      B_DIV:   if (cnt == 6'(MAG_BITS - 1)) state_next = B_SIGN;
      B_SIGN:  state_next = B_OUT;
      B_OUT:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        job <= q_job;
        k   <= '0;
        sum <= '0;
        n   <= '0;
      end
      B_FETCH: begin
        if (!step_en) k <= k + 1'b1;
      end
      B_WAIT: begin
        res <= rd_data;
        sum <= sum + rd_ext;
        n   <= n + 1'b1;
        k   <= k + 1'b1;
      end
      B_DPREP: begin
        neg <= sum[SUM_BITS-1];
        dvd <= sum[SUM_BITS-1] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
        rem <= '0;
        cnt <= '0;
      end
      B_DIV: begin
        cnt <= cnt + 1'b1;
        if (trial >= {1'b0, n}) begin
          rem <= 4'(trial - {1'b0, n});
          dvd <= {dvd[MAG_BITS-2:0], 1'b1};
        end else begin
          rem <= trial[3:0];
          dvd <= {dvd[MAG_BITS-2:0], 1'b0};
        end
      end
      B_SIGN: begin
        res <= neg ? VALUE_BITS'(-dvd) : VALUE_BITS'(dvd);
      end
      B_OUT: begin
        if (out_free) begin
          m_tdata <= res;
          m_tlast <= job.last;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
